@@ rtl/vector3_normalize_project_macros.svh @@
// Assertion macros shared by the checker of the vector normalise and project block.
`ifndef VECTOR3_NORMALIZE_PROJECT_MACROS_SVH
`define VECTOR3_NORMALIZE_PROJECT_MACROS_SVH

// A clocked assertion that is switched off while reset is high.
`define VNP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// A clocked assertion that is also checked through reset.
`define VNP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/vnp_pkg.sv @@
// Types, constants and helpers for the vector normalise and project block.
package vnp_pkg;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
   } vnp_req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic [1:0]         skip_reason;
   } vnp_rsp_type;

   // Everything one item carries down the pipeline.
   typedef struct packed {
      logic             kind;
      logic [2:0][31:0] a;
      logic [2:0][31:0] v;
      logic [1:0]       reason;
      logic [63:0]      sum;
      logic [63:0]      root;
      logic [31:0]      len;
      logic [2:0]       neg;
      logic [2:0][31:0] rem;
      logic [2:0][47:0] dq;
      logic [31:0]      dot;
      logic [2:0][63:0] prod;
   } vnp_stage_type;

   localparam logic [1:0] SKIP_NONE = 2'd0;
   localparam logic [1:0] SKIP_UNIT = 2'd1;
   localparam logic [1:0] SKIP_ZERO = 2'd2;

   localparam logic [15:0] EPS_RESET = 16'd66;
   localparam logic [47:0] ONE_Q16   = 48'd65536;

   localparam int NUM_STAGES   = 49;
   localparam int ST_SUM       = 1;
   localparam int ST_UNIT      = 2;
   localparam int SQ_FIRST     = 3;
   localparam int SQ_STAGES    = 16;
   localparam int ST_SETUP     = SQ_FIRST + SQ_STAGES;
   localparam int DIV_FIRST    = ST_SETUP + 1;
   localparam int DIV_STAGES   = 24;
   localparam int ST_FIX       = DIV_FIRST + DIV_STAGES;
   localparam int ST_DOT_MUL   = ST_FIX + 1;
   localparam int ST_DOT_SUM   = ST_FIX + 2;
   localparam int ST_PRJ_MUL   = ST_FIX + 3;
   localparam int ST_OUT       = ST_FIX + 4;

   localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
   localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

   function automatic logic [31:0] sat_q16(input logic signed [49:0] x);
      logic [31:0] r;
      if (x > SAT_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (x < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/vector3_normalize_project.sv @@
// Top level of the 3-vector normalise and project pipeline.
//
//   channel   direction   handshake            content
//   req       in          req_valid/req_stall  kind, vectors a and b
//   rsp       out         rsp_valid/rsp_stall  result vector, skip reason
//   csr       in          csr_wr_en            epsilon
//
// One item enters per cycle while no stalled result holds the pipeline.
// The pipeline holds the square root (two bits a stage, 16 stages) and
// the three dividers (two quotient bits a stage, 24 stages).
// Reset clears the valid bits and sets epsilon to 66.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
module vector3_normalize_project (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  vnp_pkg::vnp_req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vnp_pkg::vnp_rsp_type rsp_payload,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);
   import vnp_pkg::*;

   logic [15:0]            epsilon_ff;
   logic [NUM_STAGES-1:0]  valid_ff;
   vnp_stage_type          stage_ff [NUM_STAGES];
   vnp_stage_type          stage_in [NUM_STAGES];
   logic                   advance;
   logic [2:0][31:0]       in_a;
   logic [2:0][31:0]       in_v;

   assign advance   = !(valid_ff[NUM_STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         epsilon_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_a = {req_payload.az, req_payload.ay, req_payload.ax};
   assign in_v = req_payload.kind ? {req_payload.bz, req_payload.by, req_payload.bx} : in_a;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_square
         // The vector to be normalised is b when projecting, else a.
         always_comb begin
            stage_in[s]      = '0;
            stage_in[s].kind = req_payload.kind;
            stage_in[s].a    = in_a;
            stage_in[s].v    = in_v;
            for (int i = 0; i < 3; i++) begin
               stage_in[s].prod[i] = $signed(in_v[i]) * $signed(in_v[i]);
            end
         end
      end else if (s == ST_SUM) begin : g_sum
         always_comb begin
            stage_in[s]     = stage_ff[s-1];
            stage_in[s].sum = stage_ff[s-1].prod[0] + stage_ff[s-1].prod[1]
                            + stage_ff[s-1].prod[2];
         end
      end else if (s == ST_UNIT) begin : g_unit
         logic [47:0] n16;
         logic [47:0] diff;
         always_comb begin
            n16  = stage_ff[s-1].sum[63:16];
            diff = (n16 >= ONE_Q16) ? n16 - ONE_Q16 : ONE_Q16 - n16;
            stage_in[s]        = stage_ff[s-1];
            stage_in[s].root   = '0;
            stage_in[s].reason = (diff <= {32'd0, epsilon_ff}) ? SKIP_UNIT : SKIP_NONE;
         end
      end else if (s >= SQ_FIRST && s < SQ_FIRST + SQ_STAGES) begin : g_sqrt
         logic [63:0] rem_w;
         logic [63:0] root_w;
         logic [63:0] bit_w;
         logic [63:0] trial;
         always_comb begin
            rem_w  = stage_ff[s-1].sum;
            root_w = stage_ff[s-1].root;
            for (int t = 0; t < 2; t++) begin
               bit_w = 64'd1 << (62 - 2 * (2 * (s - SQ_FIRST) + t));
               trial = root_w + bit_w;
               if (rem_w >= trial) begin
                  rem_w  = rem_w - trial;
                  root_w = (root_w >> 1) + bit_w;
               end else begin
                  root_w = root_w >> 1;
               end
            end
            stage_in[s]      = stage_ff[s-1];
            stage_in[s].sum  = rem_w;
            stage_in[s].root = root_w;
         end
      end else if (s == ST_SETUP) begin : g_setup
         logic [31:0] mag;
         always_comb begin
            stage_in[s]     = stage_ff[s-1];
            stage_in[s].len = stage_ff[s-1].root[31:0];
            if (stage_ff[s-1].reason == SKIP_NONE
                && stage_ff[s-1].root[31:0] <= {16'd0, epsilon_ff}) begin
               stage_in[s].reason = SKIP_ZERO;
            end
            mag = '0;
            for (int i = 0; i < 3; i++) begin
               stage_in[s].neg[i] = stage_ff[s-1].v[i][31];
               mag = stage_ff[s-1].v[i][31] ? 32'd0 - stage_ff[s-1].v[i] : stage_ff[s-1].v[i];
               stage_in[s].dq[i]  = {mag, 16'd0};
               stage_in[s].rem[i] = '0;
            end
         end
      end else if (s >= DIV_FIRST && s < DIV_FIRST + DIV_STAGES) begin : g_div
         logic [32:0] r2;
         logic [31:0] rem_w;
         logic [47:0] dq_w;
         logic        qb;
         always_comb begin
            stage_in[s] = stage_ff[s-1];
            r2    = '0;
            rem_w = '0;
            dq_w  = '0;
            qb    = 1'b0;
            for (int i = 0; i < 3; i++) begin
               rem_w = stage_ff[s-1].rem[i];
               dq_w  = stage_ff[s-1].dq[i];
               for (int t = 0; t < 2; t++) begin
                  r2 = {rem_w, dq_w[47]};
                  qb = (r2 >= {1'b0, stage_ff[s-1].len});
                  if (qb) begin
                     r2 = r2 - {1'b0, stage_ff[s-1].len};
                  end
                  rem_w = r2[31:0];
                  dq_w  = {dq_w[46:0], qb};
               end
               stage_in[s].rem[i] = rem_w;
               stage_in[s].dq[i]  = dq_w;
            end
         end
      end else if (s == ST_FIX) begin : g_fix
         logic [47:0] q;
         logic [47:0] nq;
         always_comb begin
            stage_in[s] = stage_ff[s-1];
            q  = '0;
            nq = '0;
            if (stage_ff[s-1].reason == SKIP_NONE) begin
               for (int i = 0; i < 3; i++) begin
                  q  = stage_ff[s-1].dq[i];
                  nq = 48'd0 - q;
                  if (stage_ff[s-1].neg[i]) begin
                     stage_in[s].v[i] = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : nq[31:0];
                  end else begin
                     stage_in[s].v[i] = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
                  end
               end
            end
         end
      end else if (s == ST_DOT_MUL) begin : g_dot_mul
         always_comb begin
            stage_in[s] = stage_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               stage_in[s].prod[i] = $signed(stage_ff[s-1].a[i]) * $signed(stage_ff[s-1].v[i]);
            end
         end
      end else if (s == ST_DOT_SUM) begin : g_dot_sum
         logic signed [49:0] acc;
         always_comb begin
            acc = 50'($signed(stage_ff[s-1].prod[0][63:16]))
                + 50'($signed(stage_ff[s-1].prod[1][63:16]))
                + 50'($signed(stage_ff[s-1].prod[2][63:16]));
            stage_in[s]     = stage_ff[s-1];
            stage_in[s].dot = sat_q16(acc);
         end
      end else if (s == ST_PRJ_MUL) begin : g_prj_mul
         always_comb begin
            stage_in[s] = stage_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               stage_in[s].prod[i] = $signed(stage_ff[s-1].v[i]) * $signed(stage_ff[s-1].dot);
            end
         end
      end else begin : g_out
         // In normalise mode the normalised vector is already the result.
         always_comb begin
            stage_in[s] = stage_ff[s-1];
            if (stage_ff[s-1].kind) begin
               for (int i = 0; i < 3; i++) begin
                  stage_in[s].v[i] = sat_q16(50'($signed(stage_ff[s-1].prod[i][63:16])));
               end
            end
         end
      end
   end

   assign rsp_valid               = valid_ff[NUM_STAGES-1];
   assign rsp_payload.rx          = stage_ff[NUM_STAGES-1].v[0];
   assign rsp_payload.ry          = stage_ff[NUM_STAGES-1].v[1];
   assign rsp_payload.rz          = stage_ff[NUM_STAGES-1].v[2];
   assign rsp_payload.skip_reason = stage_ff[NUM_STAGES-1].reason;

endmodule

@@ rtl/vnp_checker.sv @@
// Port checker for the vector normalise and project block, with its bind.
`include "vector3_normalize_project_macros.svh"

module vnp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input vnp_pkg::vnp_rsp_type rsp_payload
);
   import vnp_pkg::*;

   // A waiting result stays offered.
   `VNP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // The input side only stalls when the result side does.
   `VNP_ASSERT(a_stall_cause, clock, reset, !rsp_stall |-> !req_stall)

   `VNP_ASSERT(a_reason_code, clock, reset, rsp_valid |-> rsp_payload.skip_reason <= SKIP_ZERO)

   // Reset empties the pipeline.
   `VNP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind vector3_normalize_project vnp_checker u_vnp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ test/vector3_normalize_project_tb.sv @@
// Testbench for the vector normalise and project block: directed table, then random items.
module vector3_normalize_project_tb;
   import vnp_pkg::*;

   localparam int LATENCY = 49;
   localparam int LIMIT   = 400000;

   typedef struct {
      logic        kind;
      logic [31:0] ax, ay, az, bx, by, bz;
      logic        known;
      logic [31:0] rx, ry, rz;
      logic [1:0]  reason;
   } vec_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   vnp_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   vnp_rsp_type rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   vnp_rsp_type expected_results[$];
   logic [15:0] tolerance;
   int          errors = 0;
   int          cycles = 0;
   bit          calm = 1'b0;
   vec_row_type directed_rows[$];

   vector3_normalize_project dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_q16(longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] bitv;
      r = '0;
      rem = n;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > rem) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (rem >= r + bitv) begin
            rem = rem - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Normalises v in place, unless the vector is skipped, and returns the skip reason.
   function automatic logic [1:0] unit_vector(ref longint v[3]);
      logic [63:0] sum;
      logic [63:0] n16;
      logic [63:0] diff;
      logic [63:0] len;
      logic [63:0] mag;
      longint      q;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         sum += 64'(v[i] * v[i]);
      end
      n16 = sum >> 16;
      diff = (n16 >= 65536) ? n16 - 65536 : 65536 - n16;
      if (diff <= tolerance) begin
         return SKIP_UNIT;
      end
      len = root_floor(sum);
      if (len <= tolerance) begin
         return SKIP_ZERO;
      end
      for (int i = 0; i < 3; i++) begin
         mag = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
         q = longint'((mag << 16) / len);
         v[i] = clamp_q16((v[i] < 0) ? -q : q);
      end
      return SKIP_NONE;
   endfunction

   function automatic vnp_rsp_type predict_vector(vnp_req_type p);
      longint      a[3];
      longint      b[3];
      longint      d;
      vnp_rsp_type r;
      a = '{longint'(p.ax), longint'(p.ay), longint'(p.az)};
      b = '{longint'(p.bx), longint'(p.by), longint'(p.bz)};
      if (!p.kind) begin
         r.skip_reason = unit_vector(a);
      end else begin
         r.skip_reason = unit_vector(b);
         d = 0;
         for (int i = 0; i < 3; i++) begin
            d += (a[i] * b[i]) >>> 16;
         end
         d = clamp_q16(d);
         for (int i = 0; i < 3; i++) begin
            a[i] = clamp_q16((b[i] * d) >>> 16);
         end
      end
      r.rx = a[0][31:0];
      r.ry = a[1][31:0];
      r.rz = a[2][31:0];
      return r;
   endfunction

   function automatic logic [31:0] random_component();
      unique case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 131072)) - 65536);
         2: return 32'($signed($urandom_range(0, 400)) - 200);
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
         default: return 32'($signed($urandom_range(0, 4194304)) - 2097152);
      endcase
   endfunction

   function automatic vec_row_type make_row(logic kind, logic [31:0] ax, logic [31:0] ay,
                                            logic [31:0] az, logic [31:0] bx,
                                            logic [31:0] by, logic [31:0] bz);
      vec_row_type r;
      r = '{kind, ax, ay, az, bx, by, bz, 1'b0, '0, '0, '0, SKIP_NONE};
      return r;
   endfunction

   // The valid stays high after an accept; the next call or its caller decides what follows.
   task automatic send_vector(vnp_req_type p, logic known, vnp_rsp_type fixed);
      while (!calm && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_results.push_back(known ? fixed : predict_vector(p));
   endtask

   task automatic set_tolerance(logic [15:0] e);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= e;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tolerance = e;
   endtask

   task automatic random_phase(int count);
      vnp_req_type p;
      for (int n = 0; n < count; n++) begin
         calm = (n >= count / 3) && (n < count / 3 + 40);
         p.kind = 1'($urandom_range(0, 1));
         p.ax = random_component();
         p.ay = random_component();
         p.az = random_component();
         p.bx = random_component();
         p.by = random_component();
         p.bz = random_component();
         send_vector(p, 1'b0, '0);
      end
      calm = 1'b0;
   endtask

   // Result side: random stall, compare with the oldest expectation.
   always @(posedge clock) begin
      vnp_rsp_type e;
      cycles <= cycles + 1;
      if (!reset) begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected");
               errors = errors + 1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_payload.rx !== e.rx) begin
                  $error("rx expected %h actual %h", e.rx, rsp_payload.rx);
                  errors = errors + 1;
               end
               if (rsp_payload.ry !== e.ry) begin
                  $error("ry expected %h actual %h", e.ry, rsp_payload.ry);
                  errors = errors + 1;
               end
               if (rsp_payload.rz !== e.rz) begin
                  $error("rz expected %h actual %h", e.rz, rsp_payload.rz);
                  errors = errors + 1;
               end
               if (rsp_payload.skip_reason !== e.skip_reason) begin
                  $error("skip_reason expected %0d actual %0d", e.skip_reason,
                         rsp_payload.skip_reason);
                  errors = errors + 1;
               end
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      vec_row_type row;
      vnp_req_type p;
      vnp_rsp_type fixed;
      tolerance = EPS_RESET;
      // A zero vector is near zero; a unit vector passes unchanged.
      row = make_row(1'b0, 0, 0, 0, 0, 0, 0);
      row.known = 1'b1;
      row.reason = SKIP_ZERO;
      directed_rows.push_back(row);
      row = make_row(1'b0, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF, 0, 0);
      row.known = 1'b1;
      row.rx = 32'h0001_0000;
      row.reason = SKIP_UNIT;
      directed_rows.push_back(row);
      row = make_row(1'b0, 0, 32'hFFFF_0000, 0, 0, 0, 0);
      row.known = 1'b1;
      row.ry = 32'hFFFF_0000;
      row.reason = SKIP_UNIT;
      directed_rows.push_back(row);
      row = make_row(1'b0, 32'h0000_0020, 0, 32'hFFFF_FFF0, 0, 0, 0);
      row.known = 1'b1;
      row.rx = 32'h0000_0020;
      row.rz = 32'hFFFF_FFF0;
      row.reason = SKIP_ZERO;
      directed_rows.push_back(row);
      directed_rows.push_back(make_row(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       0, 0, 0));
      directed_rows.push_back(make_row(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 0, 0));
      directed_rows.push_back(make_row(1'b0, 32'h8000_0000, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(1'b0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0));
      directed_rows.push_back(make_row(1'b0, 32'h0000_0050, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                       32'h0001_0000, 0, 0));
      directed_rows.push_back(make_row(1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                       0, 32'h0005_0000, 0));
      directed_rows.push_back(make_row(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      directed_rows.push_back(make_row(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      directed_rows.push_back(make_row(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                       32'h8000_0000, 32'h7FFF_FFFF, 0));
      directed_rows.push_back(make_row(1'b1, 32'h0005_0000, 32'h0006_0000, 0, 0, 0, 0));
      directed_rows.push_back(make_row(1'b1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF,
                                       32'h0000_0010, 32'h0000_0010, 0));
      directed_rows.push_back(make_row(1'b1, 32'h1234_5678, 32'hFEDC_BA98, 32'h0001_0000,
                                       32'h0000_B505, 32'h0000_B505, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         p = '{row.kind, row.ax, row.ay, row.az, row.bx, row.by, row.bz};
         fixed = '{row.rx, row.ry, row.rz, row.reason};
         send_vector(p, row.known, fixed);
      end
      random_phase(250);
      set_tolerance(16'd0);
      directed_rows.delete();
      send_vector('{1'b0, 32'h0001_0000, 0, 0, 0, 0, 0}, 1'b1,
                  '{32'h0001_0000, 32'd0, 32'd0, SKIP_UNIT});
      send_vector('{1'b0, 0, 0, 0, 0, 0, 0}, 1'b1, '{32'd0, 32'd0, 32'd0, SKIP_ZERO});
      random_phase(200);
      set_tolerance(16'hFFFF);
      random_phase(150);
      set_tolerance(16'($urandom_range(1, 4000)));
      random_phase(200);
      set_tolerance(EPS_RESET);
      random_phase(50);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
